FILE: hdl/pdvc_pkg.sv
package pdvc_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int QDEPTH           = 2;

  // shared divider: unsigned dividend and divisor widths
  localparam int DIV_NW = 64;
  localparam int DIV_DW = 34;

  // CORDIC angle accumulator width (Q2.30 plus headroom)
  localparam int ZW = 34;

  localparam logic signed [ZW-1:0] Q30_PI       = 34'sd3373259426;
  localparam logic signed [ZW-1:0] Q30_HALF_PI  = 34'sd1686629713;
  localparam logic signed [63:0]   Q30_INV_GAIN = 64'sd652032874;
  localparam logic signed [63:0]   COS_MIN      = 64'sd16384;
  localparam logic signed [31:0]   INT32_MAX    = 32'sh7FFF_FFFF;
  localparam logic signed [31:0]   INT32_MIN    = 32'sh8000_0000;

  // register map indexes
  localparam logic [2:0] REG_DRONE_TYPE   = 3'd0;
  localparam logic [2:0] REG_MASS_DRONE   = 3'd1;
  localparam logic [2:0] REG_MASS_CARGO   = 3'd2;
  localparam logic [2:0] REG_TAU_X        = 3'd3;
  localparam logic [2:0] REG_TAU_Y        = 3'd4;
  localparam logic [2:0] REG_TAU_THETA    = 3'd5;
  localparam logic [2:0] REG_DAMPING_GAIN = 3'd6;
  localparam logic [2:0] REG_GRAVITY      = 3'd7;

  localparam logic [23:0] RST_ONE     = 24'd65536;
  localparam logic [23:0] RST_GRAVITY = 24'd642908;

  typedef struct packed {
    logic               drone_type;
    logic [23:0]        mass_drone;
    logic [23:0]        mass_cargo;
    logic [23:0]        tau_x;
    logic [23:0]        tau_y;
    logic [23:0]        tau_theta;
    logic signed [31:0] damping_gain;
    logic [23:0]        gravity;
  } cfg_t;

  // one classified sample: velocity errors, cargo offset and pitch
  typedef struct packed {
    logic signed [32:0] ex;
    logic signed [32:0] ey;
    logic signed [32:0] dc;
    logic signed [18:0] pitch;
  } item_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] v;
    unique case (idx)
      5'd0:  v = 30'h3243F6A8;
      5'd1:  v = 30'h1DAC6705;
      5'd2:  v = 30'h0FADBAFC;
      5'd3:  v = 30'h07F56EA6;
      5'd4:  v = 30'h03FEAB76;
      5'd5:  v = 30'h01FFD55B;
      5'd6:  v = 30'h00FFFAAA;
      5'd7:  v = 30'h007FFF55;
      5'd8:  v = 30'h003FFFEA;
      5'd9:  v = 30'h001FFFFD;
      5'd10: v = 30'h000FFFFF;
      5'd11: v = 30'h0007FFFF;
      5'd12: v = 30'h0003FFFF;
      5'd13: v = 30'h0001FFFF;
      5'd14: v = 30'h0000FFFF;
      5'd15: v = 30'h00007FFF;
      5'd16: v = 30'h00003FFF;
      5'd17: v = 30'h00001FFF;
      5'd18: v = 30'h00000FFF;
      5'd19: v = 30'h000007FF;
      5'd20: v = 30'h000003FF;
      5'd21: v = 30'h000001FF;
      5'd22: v = 30'h000000FF;
      5'd23: v = 30'h0000007F;
      5'd24: v = 30'h0000003F;
      5'd25: v = 30'h0000001F;
      5'd26: v = 30'h0000000F;
      5'd27: v = 30'h00000007;
      5'd28: v = 30'h00000003;
      5'd29: v = 30'h00000001;
      default: v = 30'h0;
    endcase
    return v;
  endfunction

endpackage

FILE: hdl/pdvc_front.sv
module pdvc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [31:0]  drone_x_i,
  input  logic signed [18:0]  pitch_angle_i,
  input  logic signed [31:0]  vel_x_i,
  input  logic signed [31:0]  vel_y_i,
  input  logic signed [31:0]  cargo_x_i,
  input  logic signed [31:0]  vel_ref_x_i,
  input  logic signed [31:0]  vel_ref_y_i,
  output logic                q_valid_o,
  output pdvc_pkg::item_t     q_item_o,
  input  logic                q_pop_i
);
  import pdvc_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  item_t          mem_q [QDEPTH];
  item_t          item_d;
  logic [PW-1:0]  wr_q, rd_q;
  logic [CW-1:0]  cnt_q;
  logic           push;

  always_comb begin
    item_d.ex    = 33'(vel_ref_x_i) - 33'(vel_x_i);
    item_d.ey    = 33'(vel_ref_y_i) - 33'(vel_y_i);
    item_d.dc    = 33'(cargo_x_i) - 33'(drone_x_i);
    item_d.pitch = pitch_angle_i;
  end

  assign in_ready_o = (cnt_q != CW'(QDEPTH));
  assign push       = in_valid_i & in_ready_o;
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PW'(QDEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (q_pop_i) begin
        rd_q <= (rd_q == PW'(QDEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      cnt_q <= cnt_q + CW'(push) - CW'(q_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= item_d;
    end
  end

`ifndef SYNTHESIS
  a_pop_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> q_valid_o) else $error("pop from empty queue");
  a_push_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 && push) |=> q_valid_o) else $error("pushed item lost");
`endif

endmodule

FILE: hdl/pdvc_div.sv
module pdvc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [pdvc_pkg::DIV_NW-1:0]   dividend_i,
  input  logic [pdvc_pkg::DIV_DW-1:0]   divisor_i,
  output logic [pdvc_pkg::DIV_NW-1:0]   quot_o,
  output logic                          done_o
);
  import pdvc_pkg::*;

  localparam int CNW = $clog2(DIV_NW);

  logic [CNW-1:0]     cnt_q;
  logic               busy_q, done_q;
  logic [DIV_DW-1:0]  rem_q, dvs_q;
  logic [DIV_NW-1:0]  dq_q;
  logic [DIV_DW:0]    trial;
  logic               ge;
  logic [DIV_DW-1:0]  rem_n;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial = {rem_q, dq_q[DIV_NW-1]};
    ge    = (trial >= {1'b0, dvs_q});
    rem_n = ge ? DIV_DW'(trial - {1'b0, dvs_q}) : trial[DIV_DW-1:0];
  end

  assign quot_o = dq_q;
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNW'(1);
        if (cnt_q == CNW'(DIV_NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      dq_q  <= {dq_q[DIV_NW-2:0], ge};
      rem_q <= rem_n;
    end
  end

endmodule

FILE: hdl/pdvc_cordic.sv
module pdvc_cordic #(
  parameter int CORDIC_STEPS = pdvc_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                vec_i,
  input  logic signed [63:0]  a_i,
  input  logic signed [63:0]  b_i,
  output logic signed [63:0]  res_o,
  output logic                done_o
);
  import pdvc_pkg::*;

  localparam int IW = $clog2(CORDIC_STEPS);

  logic [IW-1:0]         cnt_q;
  logic                  busy_q, done_q;
  logic                  vec_q, zero_q, neg_q;
  logic signed [63:0]    x_q, y_q, x0, y0, xs, ys;
  logic signed [ZW-1:0]  z_q, z0, p0, at;
  logic                  zero0, neg0, plus;

  // quadrant fold on entry
  always_comb begin
    x0    = b_i;
    y0    = a_i;
    z0    = '0;
    zero0 = 1'b0;
    neg0  = 1'b0;
    p0    = a_i[ZW-1:0];
    if (vec_i) begin
      zero0 = (a_i == '0) && (b_i == '0);
      if (b_i < 0) begin
        if (a_i >= 0) begin
          x0 = a_i;
          y0 = -b_i;
          z0 = Q30_HALF_PI;
        end else begin
          x0 = -a_i;
          y0 = b_i;
          z0 = -Q30_HALF_PI;
        end
      end
    end else begin
      x0 = Q30_INV_GAIN;
      y0 = '0;
      if (p0 > Q30_HALF_PI) begin
        z0   = p0 - Q30_PI;
        neg0 = 1'b1;
      end else if (p0 < -Q30_HALF_PI) begin
        z0   = p0 + Q30_PI;
        neg0 = 1'b1;
      end else begin
        z0 = p0;
      end
    end
  end

  always_comb begin
    xs   = x_q >>> 5'(cnt_q);
    ys   = y_q >>> 5'(cnt_q);
    at   = $signed({4'b0, atan_q30(5'(cnt_q))});
    plus = vec_q ? (y_q > 0) : (z_q < 0);
  end

  assign res_o  = vec_q ? (zero_q ? 64'sd0 : 64'(z_q)) : (neg_q ? -x_q : x_q);
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + IW'(1);
        if (cnt_q == IW'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= x0;
      y_q    <= y0;
      z_q    <= z0;
      vec_q  <= vec_i;
      zero_q <= zero0;
      neg_q  <= neg0;
    end else if (busy_q) begin
      if (plus) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= vec_q ? z_q + at : z_q + at;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end
    end
  end

endmodule

FILE: hdl/pdvc_back.sv
module pdvc_back #(
  parameter int CORDIC_STEPS = pdvc_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pdvc_pkg::cfg_t      cfg_i,
  input  logic                q_valid_i,
  input  pdvc_pkg::item_t     q_item_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  thrust_o,
  output logic signed [31:0]  angular_rate_o,
  output logic                saturated_o
);
  import pdvc_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_MD   = 5'd1;
  localparam logic [4:0] S_MG   = 5'd2;
  localparam logic [4:0] S_MX   = 5'd3;
  localparam logic [4:0] S_DXS  = 5'd4;
  localparam logic [4:0] S_DXW  = 5'd5;
  localparam logic [4:0] S_MY   = 5'd6;
  localparam logic [4:0] S_DYS  = 5'd7;
  localparam logic [4:0] S_DYW  = 5'd8;
  localparam logic [4:0] S_ATS  = 5'd9;
  localparam logic [4:0] S_ATW  = 5'd10;
  localparam logic [4:0] S_COS  = 5'd11;
  localparam logic [4:0] S_COW  = 5'd12;
  localparam logic [4:0] S_TS   = 5'd13;
  localparam logic [4:0] S_TW   = 5'd14;
  localparam logic [4:0] S_RS   = 5'd15;
  localparam logic [4:0] S_RW   = 5'd16;
  localparam logic [4:0] S_DONE = 5'd17;

  logic [4:0]          st_q;
  item_t               it_q;
  logic [24:0]         m_q;
  logic signed [67:0]  prod_q, pabs;
  logic signed [63:0]  fx_q, fy_q, c_q, ac, afy, qs;
  logic                neg_q, flag_q, negres;
  logic signed [19:0]  theta_q;
  logic signed [20:0]  err, aerr;
  logic signed [31:0]  thrust_q, rate_q;
  logic                out_valid_q;
  logic signed [31:0]  out_thrust_q, out_rate_q;
  logic                out_sat_q;
  logic signed [33:0]  mul_a, mul_b;
  logic signed [64:0]  rv;

  logic                 div_start, div_done;
  logic [DIV_NW-1:0]    div_nd, div_q;
  logic [DIV_DW-1:0]    div_dv;
  logic                 cor_start, cor_vec, cor_done;
  logic signed [63:0]   cor_a, cor_b, cor_res;

  function automatic logic [DIV_DW-1:0] nz(input logic [23:0] t);
    return (t == '0) ? DIV_DW'(1) : DIV_DW'(t);
  endfunction

  assign pabs   = prod_q[67] ? -prod_q : prod_q;
  assign ac     = c_q[63] ? -c_q : c_q;
  assign afy    = fy_q[63] ? -fy_q : fy_q;
  assign negres = fy_q[63] ^ c_q[63];
  assign err    = 21'(theta_q) - 21'(it_q.pitch);
  assign aerr   = err[20] ? -err : err;
  assign qs     = neg_q ? -$signed(div_q) : $signed(div_q);
  assign rv     = neg_q ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});

  // operand select for the shared multiplier
  always_comb begin
    mul_a = $signed({9'b0, m_q});
    mul_b = 34'(it_q.ex);
    unique case (st_q)
      S_MD: begin
        mul_a = 34'(cfg_i.damping_gain);
        mul_b = 34'(it_q.dc);
      end
      S_MG:    mul_b = $signed({10'b0, cfg_i.gravity});
      S_MY:    mul_b = 34'(it_q.ey);
      default: mul_b = 34'(it_q.ex);
    endcase
  end

  // divider and CORDIC launch
  always_comb begin
    div_start = 1'b0;
    div_nd    = pabs[DIV_NW-1:0];
    div_dv    = nz(cfg_i.tau_x);
    cor_start = 1'b0;
    cor_vec   = 1'b1;
    cor_a     = -fx_q;
    cor_b     = fy_q;
    unique case (st_q)
      S_DXS: div_start = 1'b1;
      S_DYS: begin
        div_start = 1'b1;
        div_dv    = nz(cfg_i.tau_y);
      end
      S_TS: begin
        div_start = !(ac < COS_MIN) && !(afy >= (ac <<< 1));
        div_nd    = DIV_NW'(afy <<< 30);
        div_dv    = ac[DIV_DW-1:0];
      end
      S_RS: begin
        div_start = 1'b1;
        div_nd    = DIV_NW'({aerr, 16'b0});
        div_dv    = nz(cfg_i.tau_theta);
      end
      S_ATS: cor_start = 1'b1;
      S_COS: begin
        cor_start = 1'b1;
        cor_vec   = 1'b0;
        cor_a     = 64'(it_q.pitch) <<< 14;
      end
      default: ;
    endcase
  end

  assign q_pop_o        = (st_q == S_IDLE) && q_valid_i;
  assign out_valid_o    = out_valid_q;
  assign thrust_o       = out_thrust_q;
  assign angular_rate_o = out_rate_q;
  assign saturated_o    = out_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (st_q == S_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (st_q)
        S_IDLE: if (q_valid_i) st_q <= S_MD;
        S_MD:   st_q <= S_MG;
        S_MG:   st_q <= S_MX;
        S_MX:   st_q <= S_DXS;
        S_DXS:  st_q <= S_DXW;
        S_DXW:  if (div_done) st_q <= S_MY;
        S_MY:   st_q <= S_DYS;
        S_DYS:  st_q <= S_DYW;
        S_DYW:  if (div_done) st_q <= S_ATS;
        S_ATS:  st_q <= S_ATW;
        S_ATW:  if (cor_done) st_q <= S_COS;
        S_COS:  st_q <= S_COW;
        S_COW:  if (cor_done) st_q <= S_TS;
        S_TS:   st_q <= div_start ? S_TW : S_RS;
        S_TW:   if (div_done) st_q <= S_RS;
        S_RS:   st_q <= S_RW;
        S_RW:   if (div_done) st_q <= S_DONE;
        S_DONE: if (!out_valid_q || out_ready_i) st_q <= S_IDLE;
        default: st_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      S_IDLE: begin
        it_q   <= q_item_i;
        m_q    <= 25'(cfg_i.mass_drone) + (cfg_i.drone_type ? 25'(cfg_i.mass_cargo) : 25'd0);
        flag_q <= 1'b0;
      end
      S_MD: prod_q <= mul_a * mul_b;
      S_MG: begin
        fx_q   <= cfg_i.drone_type ? 64'(prod_q >>> 16) : 64'sd0;
        prod_q <= mul_a * mul_b;
      end
      S_MX: begin
        fy_q   <= 64'(prod_q >>> 16);
        prod_q <= mul_a * mul_b;
      end
      S_DXS, S_DYS: neg_q <= prod_q[67];
      S_DXW: if (div_done) fx_q <= fx_q + qs;
      S_MY:  prod_q <= mul_a * mul_b;
      S_DYW: if (div_done) fy_q <= fy_q + qs;
      S_ATW: if (cor_done) theta_q <= 20'((cor_res + 64'sd8192) >>> 14);
      S_COW: if (cor_done) c_q <= cor_res;
      S_TS: begin
        neg_q <= negres;
        if (ac < COS_MIN) begin
          flag_q   <= 1'b1;
          thrust_q <= (fy_q == '0) ? 32'sd0 : (negres ? INT32_MIN : INT32_MAX);
        end else if (afy >= (ac <<< 1)) begin
          flag_q   <= 1'b1;
          thrust_q <= negres ? INT32_MIN : INT32_MAX;
        end
      end
      S_TW: if (div_done) thrust_q <= 32'(qs);
      S_RS: neg_q <= err[20];
      S_RW: begin
        if (div_done) begin
          if (rv > 65'(INT32_MAX)) begin
            rate_q <= INT32_MAX;
            flag_q <= 1'b1;
          end else if (rv < 65'(INT32_MIN)) begin
            rate_q <= INT32_MIN;
            flag_q <= 1'b1;
          end else begin
            rate_q <= 32'(rv);
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_thrust_q <= thrust_q;
          out_rate_q   <= rate_q;
          out_sat_q    <= flag_q;
        end
      end
      default: ;
    endcase
  end

  pdvc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_nd),
    .divisor_i  (div_dv),
    .quot_o     (div_q),
    .done_o     (div_done)
  );

  pdvc_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .vec_i   (cor_vec),
    .a_i     (cor_a),
    .b_i     (cor_b),
    .res_o   (cor_res),
    .done_o  (cor_done)
  );

`ifndef SYNTHESIS
  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (st_q == S_DXW || st_q == S_DYW || st_q == S_TW || st_q == S_RW))
    else $error("divider finished outside a wait state");
  a_cor_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cor_done |-> (st_q == S_ATW || st_q == S_COW))
    else $error("CORDIC finished outside a wait state");
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(st_q) == S_DONE)
    else $error("result posted without finishing a sample");
`endif

endmodule

FILE: hdl/planar_drone_velocity_controller.sv
// Planar drone velocity controller. Each input transaction carries one state
// sample (drone and cargo x position, x/y velocity and the velocity reference,
// all Q16.16, and pitch, signed Q2.16 in 19 bits) and yields one output
// transaction with thrust and pitch rate (Q16.16, saturated) plus a saturation
// flag. The front end forms the velocity errors and cargo offset and parks the
// sample in a two-entry queue, so new samples are taken while the back end is
// busy and while a finished result waits on the output register. The back end
// runs one sample at a time through a shared multiplier, one radix-2 divider
// (used up to four times) and one CORDIC unit (atan2 then cosine, CORDIC_STEPS
// iterations each); the thrust division is skipped when thrust saturates.
// Configure through the APB port only while idle: registers sit at byte
// offsets 0x00 drone_type, 0x04 mass_drone, 0x08 mass_cargo, 0x0C tau_x, 0x10
// tau_y, 0x14 tau_theta, 0x18 damping_gain, 0x1C gravity. A zero time constant
// acts as one LSB.
module planar_drone_velocity_controller #(
  parameter int CORDIC_STEPS = pdvc_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // input samples
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [31:0]  drone_x_i,
  input  logic signed [18:0]  pitch_angle_i,
  input  logic signed [31:0]  vel_x_i,
  input  logic signed [31:0]  vel_y_i,
  input  logic signed [31:0]  cargo_x_i,
  input  logic signed [31:0]  vel_ref_x_i,
  input  logic signed [31:0]  vel_ref_y_i,
  // results
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  thrust_o,
  output logic signed [31:0]  angular_rate_o,
  output logic                saturated_o
);
  import pdvc_pkg::*;

  cfg_t   cfg_q;
  item_t  q_item;
  logic   q_valid, q_pop;
  logic   wr_en;

  // APB: no wait states, write on the access phase
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.drone_type   <= 1'b0;
      cfg_q.mass_drone   <= RST_ONE;
      cfg_q.mass_cargo   <= RST_ONE;
      cfg_q.tau_x        <= RST_ONE;
      cfg_q.tau_y        <= RST_ONE;
      cfg_q.tau_theta    <= RST_ONE;
      cfg_q.damping_gain <= '0;
      cfg_q.gravity      <= RST_GRAVITY;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_DRONE_TYPE:   cfg_q.drone_type   <= pwdata[0];
        REG_MASS_DRONE:   cfg_q.mass_drone   <= pwdata[23:0];
        REG_MASS_CARGO:   cfg_q.mass_cargo   <= pwdata[23:0];
        REG_TAU_X:        cfg_q.tau_x        <= pwdata[23:0];
        REG_TAU_Y:        cfg_q.tau_y        <= pwdata[23:0];
        REG_TAU_THETA:    cfg_q.tau_theta    <= pwdata[23:0];
        REG_DAMPING_GAIN: cfg_q.damping_gain <= $signed(pwdata);
        REG_GRAVITY:      cfg_q.gravity      <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // readback, zero-extended
  always_comb begin
    unique case (paddr[4:2])
      REG_DRONE_TYPE:   prdata = {31'b0, cfg_q.drone_type};
      REG_MASS_DRONE:   prdata = {8'b0, cfg_q.mass_drone};
      REG_MASS_CARGO:   prdata = {8'b0, cfg_q.mass_cargo};
      REG_TAU_X:        prdata = {8'b0, cfg_q.tau_x};
      REG_TAU_Y:        prdata = {8'b0, cfg_q.tau_y};
      REG_TAU_THETA:    prdata = {8'b0, cfg_q.tau_theta};
      REG_DAMPING_GAIN: prdata = cfg_q.damping_gain;
      REG_GRAVITY:      prdata = {8'b0, cfg_q.gravity};
      default:          prdata = '0;
    endcase
  end

  // front end: classify and queue the sample
  pdvc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .drone_x_i     (drone_x_i),
    .pitch_angle_i (pitch_angle_i),
    .vel_x_i       (vel_x_i),
    .vel_y_i       (vel_y_i),
    .cargo_x_i     (cargo_x_i),
    .vel_ref_x_i   (vel_ref_x_i),
    .vel_ref_y_i   (vel_ref_y_i),
    .q_valid_o     (q_valid),
    .q_item_o      (q_item),
    .q_pop_i       (q_pop)
  );

  // back end: forces, pitch reference, thrust and rate
  pdvc_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .q_valid_i      (q_valid),
    .q_item_i       (q_item),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .thrust_o       (thrust_o),
    .angular_rate_o (angular_rate_o),
    .saturated_o    (saturated_o)
  );

endmodule

FILE: tb/tb_planar_drone_velocity_controller.sv
`timescale 1ns / 1ps

module tb_planar_drone_velocity_controller;
  import pdvc_pkg::*;

  localparam int STEPS = CORDIC_STEPS_DEF;
  localparam int IDLE_LIMIT = 20000;
  localparam int N_RANDOM = 1550;
  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  typedef struct {
    logic signed [31:0] thrust;
    logic signed [31:0] rate;
    logic               sat;
  } ctrl_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [31:0] drone_x_i = '0, vel_x_i = '0, vel_y_i = '0, cargo_x_i = '0;
  logic signed [31:0] vel_ref_x_i = '0, vel_ref_y_i = '0;
  logic signed [18:0] pitch_angle_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] thrust_o, angular_rate_o;
  logic saturated_o;

  // shadow of the register file
  logic        sh_type;
  longint      sh_md, sh_mc, sh_tx, sh_ty, sh_tt, sh_gain, sh_grav;

  ctrl_out_t   pending_q[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  bit          timed_out = 0;

  always #4 clk_i = ~clk_i;

  planar_drone_velocity_controller dut (.*);

  // ---------------------------------------------------------------------------
  // Predictor helpers
  // ---------------------------------------------------------------------------
  function automatic longint floor_shr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint atan_entry(int i);
    return longint'(atan_q30(5'(i)));
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z, t, nx, ny;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = HALF_PI_Q30;
      end else begin
        t = x; x = -y; y = t; z = -HALF_PI_Q30;
      end
    end
    for (int i = 0; i < STEPS; i++) begin
      if (y > 0) begin
        nx = x + floor_shr(y, i); ny = y - floor_shr(x, i); z += atan_entry(i);
      end else begin
        nx = x - floor_shr(y, i); ny = y + floor_shr(x, i); z -= atan_entry(i);
      end
      x = nx; y = ny;
    end
    return z;
  endfunction

  function automatic longint rotate_cos(longint p);
    longint x, y, nx, ny;
    bit neg;
    x = 64'sd652032874; y = 0; neg = 0;
    if (p > HALF_PI_Q30) begin
      p -= PI_Q30; neg = 1;
    end else if (p < -HALF_PI_Q30) begin
      p += PI_Q30; neg = 1;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (p >= 0) begin
        nx = x - floor_shr(y, i); ny = y + floor_shr(x, i); p -= atan_entry(i);
      end else begin
        nx = x + floor_shr(y, i); ny = y - floor_shr(x, i); p += atan_entry(i);
      end
      x = nx; y = ny;
    end
    return neg ? -x : x;
  endfunction

  function automatic longint one_lsb_min(longint t);
    return (t == 0) ? 1 : t;
  endfunction

  // Forces, reference pitch, thrust and rate for one sample.
  function automatic ctrl_out_t control_law(longint dx, longint pitch, longint vx,
                                            longint vy, longint cx, longint rx,
                                            longint ry);
    ctrl_out_t r;
    longint m, fx, fy, theta, c, ac, afy, q, err, rate;
    bit negres;
    m = sh_md + (sh_type ? sh_mc : 0);
    r.sat = 0;
    fx = (m * (rx - vx)) / one_lsb_min(sh_tx);
    if (sh_type) fx += floor_shr(sh_gain * (cx - dx), 16);
    fy = (m * (ry - vy)) / one_lsb_min(sh_ty) + floor_shr(m * sh_grav, 16);
    theta = floor_shr(vector_angle(-fx, fy) + 8192, 14);
    c = rotate_cos(pitch * 16384);
    ac = (c < 0) ? -c : c;
    afy = (fy < 0) ? -fy : fy;
    negres = (fy < 0) != (c < 0);
    if (ac < 16384) begin
      r.sat = 1;
      r.thrust = (fy == 0) ? 32'sd0 : (negres ? INT32_MIN : INT32_MAX);
    end else if (afy >= 2 * ac) begin
      r.sat = 1;
      r.thrust = negres ? INT32_MIN : INT32_MAX;
    end else begin
      q = longint'((64'(afy) << 30) / 64'(ac));
      r.thrust = 32'(negres ? -q : q);
    end
    err = theta - pitch;
    rate = (err * 65536) / one_lsb_min(sh_tt);
    if (rate > 64'sd2147483647) begin
      r.sat = 1; r.rate = INT32_MAX;
    end else if (rate < -64'sd2147483648) begin
      r.sat = 1; r.rate = INT32_MIN;
    end else begin
      r.rate = 32'(rate);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Transport
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_DRONE_TYPE:   sh_type = val[0];
      REG_MASS_DRONE:   sh_md = longint'(val[23:0]);
      REG_MASS_CARGO:   sh_mc = longint'(val[23:0]);
      REG_TAU_X:        sh_tx = longint'(val[23:0]);
      REG_TAU_Y:        sh_ty = longint'(val[23:0]);
      REG_TAU_THETA:    sh_tt = longint'(val[23:0]);
      REG_DAMPING_GAIN: sh_gain = longint'($signed(val));
      REG_GRAVITY:      sh_grav = longint'(val[23:0]);
      default: ;
    endcase
  endtask

  task automatic set_config(bit typ, logic [23:0] md, logic [23:0] mc, logic [23:0] tx,
                            logic [23:0] ty, logic [23:0] tt, logic [31:0] gain,
                            logic [23:0] grav);
    write_reg(REG_DRONE_TYPE, {31'd0, typ});
    write_reg(REG_MASS_DRONE, {8'd0, md});
    write_reg(REG_MASS_CARGO, {8'd0, mc});
    write_reg(REG_TAU_X, {8'd0, tx});
    write_reg(REG_TAU_Y, {8'd0, ty});
    write_reg(REG_TAU_THETA, {8'd0, tt});
    write_reg(REG_DAMPING_GAIN, gain);
    write_reg(REG_GRAVITY, {8'd0, grav});
  endtask

  // Send one sample; record its expected result at acceptance. Valid stays
  // high on return so a zero gap gives back-to-back transactions.
  task automatic send_sample(logic [31:0] dx, logic [18:0] pa, logic [31:0] vx,
                             logic [31:0] vy, logic [31:0] cx, logic [31:0] rx,
                             logic [31:0] ry);
    int gap;
    gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6));
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    drone_x_i <= dx; pitch_angle_i <= pa; vel_x_i <= vx; vel_y_i <= vy;
    cargo_x_i <= cx; vel_ref_x_i <= rx; vel_ref_y_i <= ry;
    do @(posedge clk_i); while (!in_ready_o);
    pending_q.push_back(control_law($signed(dx), $signed(pa), $signed(vx), $signed(vy),
                                    $signed(cx), $signed(rx), $signed(ry)));
  endtask

  // Drop valid, hold until every expected result has come back, then let the
  // back end drain.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 1) ? 32'(($urandom() & 32'h3_FFFF)) : -32'(($urandom() & 32'h3_FFFF));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [18:0] rand_pitch();
    case ($urandom_range(0, 4))
      0: return 19'sd205887;
      1: return -19'sd205887;
      2: return 19'($urandom_range(0, 1) ? 102944 : -102944) + 19'($urandom_range(0, 8) - 4);
      default: return 19'($signed($urandom_range(0, 411774)) - 205887);
    endcase
  endfunction

  task automatic random_burst(int n);
    for (int k = 0; k < n; k++)
      send_sample(rand_word(), rand_pitch(), rand_word(), rand_word(), rand_word(),
                  rand_word(), rand_word());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_defaults();
    send_sample(0, 0, 0, 0, 0, 0, 0);
    send_sample(32'h0001_0000, 19'sd51472, 32'hFFFF_0000, 32'h0002_0000, 0,
                32'h0001_0000, 0);
    drain();
  endtask

  task automatic test_directed_extremes();
    set_config(1'b1, 24'd65536, 24'd32768, 24'd65536, 24'd65536, 24'd65536,
               32'h0000_8000, 24'd642908);
    send_sample(32'h7FFF_FFFF, 19'sd205887, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_sample(32'h8000_0000, -19'sd205887, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_sample(0, 19'sd102944, 0, 0, 0, 0, 0);     // cosine near zero
    send_sample(0, -19'sd102944, 0, 0, 0, 0, 0);
    send_sample(0, 19'sd102943, 0, 32'h0010_0000, 0, 0, 0);
    send_sample(0, 19'sd150000, 0, 0, 0, 0, 0);      // pitch beyond pi/2
    send_sample(0, -19'sd150000, 0, 0, 0, 32'h0005_0000, 0);
    send_sample(0, 19'h7FFFF, 32'h0000_0001, 0, 32'h0000_0001, 0, 0);
    drain();
    // both forces zero, with gravity configured to zero
    set_config(1'b0, 24'd65536, 24'd0, 24'd65536, 24'd65536, 24'd65536, 32'd0, 24'd0);
    send_sample(0, 0, 0, 0, 0, 0, 0);
    send_sample(0, 19'sd1000, 0, 0, 0, 0, 0);
    drain();
    // zero time constants act as one LSB; huge masses force clipping
    set_config(1'b1, 24'hFF_FFFF, 24'hFF_FFFF, 24'd0, 24'd0, 24'd0, 32'h8000_0000,
               24'hFF_FFFF);
    send_sample(32'h7FFF_FFFF, 19'sd3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_sample(0, -19'sd3, 0, 0, 0, 0, 0);
    drain();
    set_config(1'b1, 24'd1, 24'd0, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 32'h7FFF_FFFF,
               24'd0);
    send_sample(32'h8000_0000, 19'sd205887, 0, 0, 32'h7FFF_FFFF, 0, 0);
    send_sample(0, 0, 0, 32'h0000_0001, 0, 0, 0);
    drain();
  endtask

  task automatic test_random_configs();
    int per_phase;
    per_phase = N_RANDOM / 10;
    for (int ph = 0; ph < 10; ph++) begin
      set_config(1'($urandom_range(0, 1)),
                 (ph == 0) ? 24'hFF_FFFF : 24'($urandom_range(1, 24'h04_0000)),
                 24'($urandom_range(0, 24'h04_0000)),
                 (ph == 1) ? 24'd1 : 24'($urandom_range(1, 24'h0FFFFF)),
                 (ph == 2) ? 24'hFF_FFFF : 24'($urandom_range(1, 24'h0FFFFF)),
                 (ph == 3) ? 24'd1 : 24'($urandom_range(1, 24'h0FFFFF)),
                 (ph == 4) ? 32'h8000_0000 : $urandom(),
                 (ph == 5) ? 24'hFF_FFFF : 24'($urandom_range(0, 24'h0FFFFF)));
      random_burst(per_phase);
      drain();
    end
    // restore reset values
    set_config(1'b0, RST_ONE, RST_ONE, RST_ONE, RST_ONE, RST_ONE, 32'd0, RST_GRAVITY);
    random_burst(N_RANDOM - 10 * per_phase + 20);
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall, then compare with the oldest expectation
  // ---------------------------------------------------------------------------
  initial begin : result_checker
    ctrl_out_t e;
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result thrust=%0d", thrust_o);
      end else begin
        e = pending_q.pop_front();
        if (thrust_o !== e.thrust || angular_rate_o !== e.rate || saturated_o !== e.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: thrust exp %0d got %0d, rate exp %0d got %0d, sat exp %0b got %0b",
                     e.thrust, thrust_o, e.rate, angular_rate_o, e.sat, saturated_o);
        end
      end
    end
  end

  // Count cycles with no transaction on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    sh_type = 0; sh_md = 65536; sh_mc = 65536; sh_tx = 65536; sh_ty = 65536;
    sh_tt = 65536; sh_gain = 0; sh_grav = 642908;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_directed_extremes();
    test_random_configs();
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/pdvc_pkg.sv
hdl/pdvc_front.sv
hdl/pdvc_div.sv
hdl/pdvc_cordic.sv
hdl/pdvc_back.sv
hdl/planar_drone_velocity_controller.sv
tb/tb_planar_drone_velocity_controller.sv
